[sv/three_channel_reload_timer_defines.svh]
// Assertion macros for the timer RTL.
// No dependencies; included by three_channel_reload_timer.
`ifndef THREE_CHANNEL_RELOAD_TIMER_DEFINES_SVH
`define THREE_CHANNEL_RELOAD_TIMER_DEFINES_SVH

`define TRC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define TRC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define TRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/trc_pkg.sv]
// Shared types, constants and decode functions for the reload timer.
// No dependencies.
package trc_pkg;

   localparam int NUM_CHANNELS = 3;
   localparam int COUNT_WIDTH  = 32;
   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DATA_W = 32;
   localparam int SEL_W  = 4;
   localparam int CMD_W  = 2;
   localparam int FLAG_W = 3;
   localparam int CTRL_W = 16;
   localparam int ACC_W  = 10;
   localparam int PSC_W  = 3;

   localparam logic [PSC_W-1:0] PSC_MASK = 3'd7;
   localparam logic [PSC_W-1:0] PSC_MAX  = 3'd4;
   localparam int UNIE_BIT = 5;
   localparam int UNF_BIT  = 8;
   localparam int ICPF_BIT = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      REG_NONE,
      REG_OUTCTL,
      REG_START,
      REG_RELOAD,
      REG_COUNT,
      REG_CONTROL
   } reg_kind_type;

   typedef struct packed {
      reg_kind_type    kind;
      logic [CH_W-1:0] ch;
   } reg_decode_type;

   typedef struct packed {
      logic tick;
      logic started;
      logic clear_psc;
      logic wr_reload;
      logic wr_count;
      logic wr_control;
   } chan_op_type;

   typedef struct packed {
      logic irq;
      logic unf;
   } chan_status_type;

   function automatic logic [ACC_W:0] step_limit(input logic [PSC_W-1:0] code);
      logic [ACC_W:0] lim;
      case (code)
         3'd0:    lim = 11'd4;
         3'd1:    lim = 11'd16;
         3'd2:    lim = 11'd64;
         3'd3:    lim = 11'd256;
         default: lim = 11'd1024;
      endcase
      return lim;
   endfunction

   function automatic reg_decode_type decode_select(input logic [SEL_W-1:0] sel);
      reg_decode_type d;
      d.kind = REG_NONE;
      d.ch   = '0;
      if (sel == SEL_W'(0)) begin
         d.kind = REG_OUTCTL;
      end else if (sel == SEL_W'(1)) begin
         d.kind = REG_START;
      end else begin
         for (int n = 0; n < NUM_CHANNELS; n++) begin
            if (int'(sel) == 2 + 3 * n) begin
               d.kind = REG_RELOAD;
               d.ch   = CH_W'(n);
            end
            if (int'(sel) == 3 + 3 * n) begin
               d.kind = REG_COUNT;
               d.ch   = CH_W'(n);
            end
            if (int'(sel) == 4 + 3 * n) begin
               d.kind = REG_CONTROL;
               d.ch   = CH_W'(n);
            end
         end
      end
      return d;
   endfunction

endpackage

[sv/trc_channel.sv]
// One timer channel: prescaler, down counter, reload and control registers.
// Depends on trc_pkg.
module trc_channel (
   input  logic                                 clock,
   input  logic                                 reset,
   input  trc_pkg::chan_op_type                 op,
   input  logic [trc_pkg::DATA_W-1:0]           write_data,
   output logic [trc_pkg::COUNT_WIDTH-1:0]      reload_value,
   output logic [trc_pkg::COUNT_WIDTH-1:0]      count_value,
   output logic [trc_pkg::CTRL_W-1:0]           control_word,
   output trc_pkg::chan_status_type             status
);

   logic [trc_pkg::COUNT_WIDTH-1:0] reload_ff, reload_in;
   logic [trc_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [trc_pkg::CTRL_W-1:0]      control_ff, control_in;
   logic [trc_pkg::ACC_W-1:0]       accum_ff, accum_in;
   logic [trc_pkg::ACC_W:0]         acc_next;
   logic [trc_pkg::PSC_W-1:0]       code;
   logic [trc_pkg::CTRL_W-1:0]      ctrl_wr;
   logic                            active;
   logic                            irq;

   assign code     = control_ff[trc_pkg::PSC_W-1:0] & trc_pkg::PSC_MASK;
   assign active   = op.tick && op.started && (code <= trc_pkg::PSC_MAX);
   assign acc_next = {1'b0, accum_ff} + (trc_pkg::ACC_W + 1)'(1);

   always_comb begin
      ctrl_wr = write_data[trc_pkg::CTRL_W-1:0];
      ctrl_wr[trc_pkg::UNF_BIT]  = write_data[trc_pkg::UNF_BIT]
                                   & control_ff[trc_pkg::UNF_BIT];
      ctrl_wr[trc_pkg::ICPF_BIT] = write_data[trc_pkg::ICPF_BIT]
                                   & control_ff[trc_pkg::ICPF_BIT];
   end

   always_comb begin
      reload_in  = reload_ff;
      count_in   = count_ff;
      control_in = control_ff;
      accum_in   = accum_ff;
      irq        = 1'b0;
      if (active) begin
         if (acc_next < trc_pkg::step_limit(code)) begin
            accum_in = acc_next[trc_pkg::ACC_W-1:0];
         end else begin
            accum_in = '0;
            if (count_ff == '0) begin
               count_in = reload_ff;
               control_in[trc_pkg::UNF_BIT] = 1'b1;
               irq = control_ff[trc_pkg::UNIE_BIT];
            end else begin
               count_in = count_ff - trc_pkg::COUNT_WIDTH'(1);
            end
         end
      end
      if (op.wr_reload) begin
         reload_in = write_data[trc_pkg::COUNT_WIDTH-1:0];
      end
      if (op.wr_count) begin
         count_in = write_data[trc_pkg::COUNT_WIDTH-1:0];
      end
      if (op.wr_control) begin
         control_in = ctrl_wr;
         if (ctrl_wr[trc_pkg::PSC_W-1:0] != control_ff[trc_pkg::PSC_W-1:0]) begin
            accum_in = '0;
         end
      end
      if (op.clear_psc) begin
         accum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff  <= '0;
         count_ff   <= '0;
         control_ff <= '0;
         accum_ff   <= '0;
      end else begin
         reload_ff  <= reload_in;
         count_ff   <= count_in;
         control_ff <= control_in;
         accum_ff   <= accum_in;
      end
   end

   assign reload_value = reload_ff;
   assign count_value  = count_ff;
   assign control_word = control_ff;
   assign status.irq   = irq;
   assign status.unf   = control_in[trc_pkg::UNF_BIT];

endmodule

[sv/three_channel_reload_timer.sv]
// Top level of the three-channel auto-reload timer: input register, register
// decode, start bits, read mux and result register. Depends on trc_pkg,
// trc_channel and three_channel_reload_timer_defines.svh.
//
//   channel | dir | tdata                                 | tuser
//   req     | in  | write_data                            | command, register_select
//   rsp     | out | read_data, interrupt_raise, underflow | -
//
// One item per cycle sustained while results are taken: an accepted item is held in the
// input register, is applied to all channels in one pass, and its result is loaded into
// the result register.
// Synchronous reset clears all timer state and both stage valids.
// A stalled result holds the input register; req_tready then drops.
`include "three_channel_reload_timer_defines.svh"

module three_channel_reload_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] write_data
   input  logic [5:0]  req_tuser,   // [1:0] command, [5:2] register_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] read_data, [34:32] interrupt_raise,
                                    // [37:35] underflow_flags, [39:38] zero
);

   logic                          in_valid_ff;
   trc_pkg::cmd_type              cmd_ff;
   logic [trc_pkg::SEL_W-1:0]     sel_ff;
   logic [trc_pkg::DATA_W-1:0]    data_ff;
   logic                          out_valid_ff;
   logic [trc_pkg::DATA_W-1:0]    rd_ff, rd_in;
   logic [trc_pkg::FLAG_W-1:0]    irq_ff, irq_in;
   logic [trc_pkg::FLAG_W-1:0]    unf_ff, unf_in;
   logic [trc_pkg::NUM_CHANNELS-1:0] start_ff, start_in, start_chg;
   logic                          advance;
   logic                          do_tick;
   logic                          do_read;
   logic                          do_write;
   trc_pkg::reg_decode_type       dec;

   logic [trc_pkg::COUNT_WIDTH-1:0] reload_val  [trc_pkg::NUM_CHANNELS];
   logic [trc_pkg::COUNT_WIDTH-1:0] count_val   [trc_pkg::NUM_CHANNELS];
   logic [trc_pkg::CTRL_W-1:0]      control_val [trc_pkg::NUM_CHANNELS];
   trc_pkg::chan_op_type            ops         [trc_pkg::NUM_CHANNELS];
   trc_pkg::chan_status_type        stats       [trc_pkg::NUM_CHANNELS];

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign dec        = trc_pkg::decode_select(sel_ff);
   assign do_tick    = advance && (cmd_ff == trc_pkg::CMD_TICK);
   assign do_read    = advance && (cmd_ff == trc_pkg::CMD_READ);
   assign do_write   = advance && (cmd_ff == trc_pkg::CMD_WRITE);
   assign start_chg  = data_ff[trc_pkg::NUM_CHANNELS-1:0] ^ start_ff;

   always_comb begin
      start_in = start_ff;
      if (do_write && dec.kind == trc_pkg::REG_START) begin
         start_in = data_ff[trc_pkg::NUM_CHANNELS-1:0];
      end
   end

   for (genvar n = 0; n < trc_pkg::NUM_CHANNELS; n++) begin : g_chan
      always_comb begin
         ops[n].tick       = do_tick;
         ops[n].started    = start_ff[n];
         ops[n].clear_psc  = do_write && (dec.kind == trc_pkg::REG_START) && start_chg[n];
         ops[n].wr_reload  = do_write && (dec.kind == trc_pkg::REG_RELOAD)
                             && (dec.ch == trc_pkg::CH_W'(n));
         ops[n].wr_count   = do_write && (dec.kind == trc_pkg::REG_COUNT)
                             && (dec.ch == trc_pkg::CH_W'(n));
         ops[n].wr_control = do_write && (dec.kind == trc_pkg::REG_CONTROL)
                             && (dec.ch == trc_pkg::CH_W'(n));
      end

      trc_channel u_channel (
         .clock        (clock),
         .reset        (reset),
         .op           (ops[n]),
         .write_data   (data_ff),
         .reload_value (reload_val[n]),
         .count_value  (count_val[n]),
         .control_word (control_val[n]),
         .status       (stats[n])
      );
   end

   for (genvar i = 0; i < trc_pkg::FLAG_W; i++) begin : g_flag
      if (i < trc_pkg::NUM_CHANNELS) begin : g_used
         assign irq_in[i] = stats[i].irq;
         assign unf_in[i] = stats[i].unf;
      end else begin : g_unused
         assign irq_in[i] = 1'b0;
         assign unf_in[i] = 1'b0;
      end
   end

   always_comb begin
      rd_in = '0;
      if (do_read) begin
         unique case (dec.kind)
            trc_pkg::REG_OUTCTL:  rd_in = trc_pkg::DATA_W'(1);
            trc_pkg::REG_START:   rd_in = trc_pkg::DATA_W'(start_ff);
            trc_pkg::REG_RELOAD:  rd_in = trc_pkg::DATA_W'(reload_val[dec.ch]);
            trc_pkg::REG_COUNT:   rd_in = trc_pkg::DATA_W'(count_val[dec.ch]);
            trc_pkg::REG_CONTROL: rd_in = trc_pkg::DATA_W'(control_val[dec.ch]);
            default:              rd_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         start_ff     <= '0;
      end else begin
         start_ff <= start_in;
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff  <= trc_pkg::cmd_type'(req_tuser[1:0]);
         sel_ff  <= req_tuser[5:2];
         data_ff <= req_tdata;
      end
      if (advance) begin
         rd_ff  <= rd_in;
         irq_ff <= (do_tick) ? irq_in : '0;
         unf_ff <= unf_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, unf_ff, irq_ff, rd_ff};

   `TRC_ASSERT_NEXT(a_hold_item, in_valid_ff && !advance, in_valid_ff, "pending item lost")
   `TRC_ASSERT_NEXT(a_result_loaded, advance, out_valid_ff, "processed item gave no result")
   `TRC_ASSERT_IMPL(a_irq_has_flag, out_valid_ff, (irq_ff & ~unf_ff) == '0,
                    "interrupt without underflow flag")
   `TRC_ASSERT(a_read_quiet, !(out_valid_ff && irq_ff != '0 && rd_ff != '0),
               "tick result carries read data")

endmodule

[tb/three_channel_reload_timer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for three_channel_reload_timer: a directed table, then random
// bursts of ticks, reads and writes, each checked against a cycle-free timer predictor.
// Depends on trc_pkg and the timer RTL.
module three_channel_reload_timer_tb;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [3:0] SEL_OUTCTL     = 4'd0;
   localparam logic [3:0] SEL_START      = 4'd1;
   localparam logic [3:0] SEL_RELOAD0    = 4'd2;
   localparam logic [3:0] SEL_COUNT0     = 4'd3;
   localparam logic [3:0] SEL_CONTROL0   = 4'd4;
   localparam logic [3:0] SEL_CONTROL1   = 4'd7;
   localparam logic [3:0] SEL_COUNT1     = 4'd6;
   localparam logic [3:0] SEL_COUNT2     = 4'd9;
   localparam logic [3:0] SEL_CONTROL2   = 4'd10;
   localparam logic [3:0] SEL_UNMAPPED   = 4'd11;
   localparam logic [3:0] SEL_TOP        = 4'd15;
   localparam int         SEL_CH_BASE    = 2;
   localparam int         SEL_STRIDE     = 3;
   localparam int         KIND_RELOAD    = 0;
   localparam int         KIND_COUNT     = 1;
   localparam int         KIND_CONTROL   = 2;
   localparam logic [31:0] OUTCTL_VALUE  = 32'd1;

   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_ITEMS   = 425;
   localparam int HOLDOFF_CYCLES = 64;
   localparam int HOLDOFF_AFTER  = 100;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [trc_pkg::DATA_W-1:0] read_data;
      logic [trc_pkg::FLAG_W-1:0] irq_raise;
      logic [trc_pkg::FLAG_W-1:0] unf_flags;
   } timer_result_type;

   typedef struct packed {
      logic [trc_pkg::CMD_W-1:0]  cmd;
      logic [trc_pkg::SEL_W-1:0]  sel;
      logic [trc_pkg::DATA_W-1:0] data;
      bit                         fixed;
      timer_result_type           result;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam stim_row_type DIRECTED_STIM [DIRECTED_ROWS] = '{
      '{trc_pkg::CMD_READ,  SEL_OUTCTL,   32'h0000_0000, 1'b1, '{OUTCTL_VALUE, 3'd0, 3'd0}},
      '{trc_pkg::CMD_READ,  SEL_START,    32'h0000_0000, 1'b1, '{32'd0, 3'd0, 3'd0}},
      '{trc_pkg::CMD_READ,  SEL_COUNT2,   32'h0000_0000, 1'b1, '{32'd0, 3'd0, 3'd0}},
      '{trc_pkg::CMD_READ,  SEL_TOP,      32'hFFFF_FFFF, 1'b1, '{32'd0, 3'd0, 3'd0}},
      '{trc_pkg::CMD_WRITE, SEL_OUTCTL,   32'hFFFF_FFFF, 1'b1, '{32'd0, 3'd0, 3'd0}},
      '{trc_pkg::CMD_READ,  SEL_OUTCTL,   32'h0000_0000, 1'b1, '{OUTCTL_VALUE, 3'd0, 3'd0}},
      '{trc_pkg::CMD_WRITE, SEL_TOP,      32'hFFFF_FFFF, 1'b1, '{32'd0, 3'd0, 3'd0}},
      '{CMD_UNUSED,         SEL_START,    32'hFFFF_FFFF, 1'b1, '{32'd0, 3'd0, 3'd0}},
      '{trc_pkg::CMD_READ,  SEL_START,    32'h0000_0000, 1'b1, '{32'd0, 3'd0, 3'd0}},
      '{trc_pkg::CMD_WRITE, SEL_RELOAD0,  32'hFFFF_FFFF, 1'b0, '0},
      '{trc_pkg::CMD_WRITE, SEL_CONTROL0, 32'h0000_FFFF, 1'b0, '0},
      '{trc_pkg::CMD_WRITE, SEL_START,    32'hFFFF_FFFF, 1'b0, '0},
      '{trc_pkg::CMD_READ,  SEL_START,    32'h0000_0000, 1'b1, '{32'd7, 3'd0, 3'd0}},
      '{trc_pkg::CMD_TICK,  SEL_TOP,      32'hFFFF_FFFF, 1'b0, '0},
      '{trc_pkg::CMD_WRITE, SEL_CONTROL0, 32'h0000_0020, 1'b0, '0},
      '{trc_pkg::CMD_TICK,  SEL_OUTCTL,   32'h0000_0000, 1'b0, '0},
      '{trc_pkg::CMD_TICK,  SEL_OUTCTL,   32'h0000_0000, 1'b0, '0},
      '{trc_pkg::CMD_TICK,  SEL_OUTCTL,   32'h0000_0000, 1'b0, '0},
      '{trc_pkg::CMD_TICK,  SEL_OUTCTL,   32'h0000_0000, 1'b0, '0},
      '{trc_pkg::CMD_READ,  SEL_COUNT0,   32'h0000_0000, 1'b0, '0},
      '{trc_pkg::CMD_WRITE, SEL_CONTROL0, 32'hFFFF_0120, 1'b0, '0},
      '{trc_pkg::CMD_WRITE, SEL_CONTROL1, 32'h0000_0000, 1'b0, '0},
      '{trc_pkg::CMD_WRITE, SEL_START,    32'h0000_0000, 1'b0, '0},
      '{trc_pkg::CMD_WRITE, SEL_COUNT1,   32'hFFFF_FFFF, 1'b0, '0},
      '{trc_pkg::CMD_READ,  SEL_CONTROL2, 32'h0000_0000, 1'b0, '0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] write_data
   logic [5:0]  req_tuser  = '0;   // [1:0] command, [5:2] register_select
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] read_data, [34:32] interrupt_raise,
                                   // [37:35] underflow_flags, [39:38] zero

   logic [trc_pkg::NUM_CHANNELS-1:0] timer_start;
   logic [trc_pkg::CTRL_W-1:0]       timer_ctrl   [trc_pkg::NUM_CHANNELS];
   logic [trc_pkg::COUNT_WIDTH-1:0]  timer_count  [trc_pkg::NUM_CHANNELS];
   logic [trc_pkg::COUNT_WIDTH-1:0]  timer_reload [trc_pkg::NUM_CHANNELS];
   int unsigned                      timer_psc    [trc_pkg::NUM_CHANNELS];

   timer_result_type pending_results[$];
   int error_count     = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int irq_predicted   = 0;
   int idle_cycles     = 0;
   bit holdoff_active  = 1'b0;
   bit holdoff_done    = 1'b0;

   three_channel_reload_timer uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic void timer_clear();
      int n;
      timer_start = '0;
      for (n = 0; n < trc_pkg::NUM_CHANNELS; n++) begin
         timer_ctrl[n]   = '0;
         timer_count[n]  = '0;
         timer_reload[n] = '0;
         timer_psc[n]    = 0;
      end
   endfunction

   function automatic timer_result_type timer_predict(
         input logic [trc_pkg::CMD_W-1:0] cmd,
         input logic [trc_pkg::SEL_W-1:0] sel,
         input logic [trc_pkg::DATA_W-1:0] data);
      timer_result_type                 res;
      int                               n, ch, kind, period;
      logic [trc_pkg::CTRL_W-1:0]       nv, sticky;
      logic [trc_pkg::NUM_CHANNELS-1:0] changed;
      res = '0;
      ch = (int'(sel) - SEL_CH_BASE) / SEL_STRIDE;
      kind = (int'(sel) - SEL_CH_BASE) % SEL_STRIDE;
      if (cmd == trc_pkg::CMD_TICK) begin
         for (n = 0; n < trc_pkg::NUM_CHANNELS; n++) begin
            if (timer_start[n] && timer_ctrl[n][trc_pkg::PSC_W-1:0] <= trc_pkg::PSC_MAX) begin
               period = 4 << (2 * int'(timer_ctrl[n][trc_pkg::PSC_W-1:0]));
               if (timer_psc[n] + 1 < period) begin
                  timer_psc[n]++;
               end else begin
                  timer_psc[n] = 0;
                  if (timer_count[n] == '0) begin
                     timer_count[n] = timer_reload[n];
                     timer_ctrl[n][trc_pkg::UNF_BIT] = 1'b1;
                     res.irq_raise[n] = timer_ctrl[n][trc_pkg::UNIE_BIT];
                  end else begin
                     timer_count[n]--;
                  end
               end
            end
         end
      end else if (cmd == trc_pkg::CMD_READ) begin
         if (sel == SEL_OUTCTL) begin
            res.read_data = OUTCTL_VALUE;
         end else if (sel == SEL_START) begin
            res.read_data = trc_pkg::DATA_W'(timer_start);
         end else if (ch < trc_pkg::NUM_CHANNELS) begin
            case (kind)
               KIND_RELOAD: res.read_data = trc_pkg::DATA_W'(timer_reload[ch]);
               KIND_COUNT:  res.read_data = trc_pkg::DATA_W'(timer_count[ch]);
               default:     res.read_data = trc_pkg::DATA_W'(timer_ctrl[ch]);
            endcase
         end
      end else if (cmd == trc_pkg::CMD_WRITE) begin
         if (sel == SEL_START) begin
            changed = data[trc_pkg::NUM_CHANNELS-1:0] ^ timer_start;
            for (n = 0; n < trc_pkg::NUM_CHANNELS; n++)
               if (changed[n]) timer_psc[n] = 0;
            timer_start = data[trc_pkg::NUM_CHANNELS-1:0];
         end else if (sel != SEL_OUTCTL && ch < trc_pkg::NUM_CHANNELS) begin
            case (kind)
               KIND_RELOAD: timer_reload[ch] = data[trc_pkg::COUNT_WIDTH-1:0];
               KIND_COUNT:  timer_count[ch]  = data[trc_pkg::COUNT_WIDTH-1:0];
               default: begin
                  sticky = '0;
                  sticky[trc_pkg::UNF_BIT] = 1'b1;
                  sticky[trc_pkg::ICPF_BIT] = 1'b1;
                  nv = data[trc_pkg::CTRL_W-1:0];
                  nv = (nv & ~sticky) | (nv & timer_ctrl[ch] & sticky);
                  if (nv[trc_pkg::PSC_W-1:0] != timer_ctrl[ch][trc_pkg::PSC_W-1:0])
                     timer_psc[ch] = 0;
                  timer_ctrl[ch] = nv;
               end
            endcase
         end
      end
      for (n = 0; n < trc_pkg::NUM_CHANNELS; n++)
         res.unf_flags[n] = timer_ctrl[n][trc_pkg::UNF_BIT];
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at result %0d: %s got %h, expected %h",
               results_checked, field, got, want);
      error_count++;
   endtask

   // hold the item until the transfer, then log its expected result
   task automatic send_item(input logic [trc_pkg::CMD_W-1:0] cmd,
                            input logic [trc_pkg::SEL_W-1:0] sel,
                            input logic [trc_pkg::DATA_W-1:0] data, input bit fixed,
                            input timer_result_type fixed_result);
      timer_result_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= {sel, cmd};
      req_tdata  <= data;
      do @(negedge clock); while (!req_tready);
      predicted = timer_predict(cmd, sel, data);
      irq_predicted += $countones(predicted.irq_raise);
      pending_results.push_back(fixed ? fixed_result : predicted);
      items_accepted++;
      @(posedge clock);
   endtask

   always @(negedge clock) begin
      timer_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata[31:0], '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[31:0] !== want.read_data)
                  report_mismatch("read_data", rsp_tdata[31:0], want.read_data);
               if (rsp_tdata[34:32] !== want.irq_raise)
                  report_mismatch("interrupt_raise", 32'(rsp_tdata[34:32]), 32'(want.irq_raise));
               if (rsp_tdata[37:35] !== want.unf_flags)
                  report_mismatch("underflow_flags", 32'(rsp_tdata[37:35]), 32'(want.unf_flags));
            end
            results_checked++;
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
               $display("== FAIL ==");
               $finish;
            end
         end
      end
   end

   initial begin
      int mode, span, phase;
      phase = 0;
      while (reset) @(posedge clock);
      forever begin
         if (!holdoff_done && results_checked >= HOLDOFF_AFTER) begin
            holdoff_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_active = 1'b0;
            holdoff_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 40);
         repeat (span) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (phase % 3) != 0;
               default: rsp_tready <= $urandom_range(0, 3) == 0;
            endcase
            phase++;
            @(posedge clock);
         end
      end
   end

   initial begin
      int                         burst_left, gap, pick, kind;
      logic [trc_pkg::CMD_W-1:0]  cmd;
      logic [trc_pkg::SEL_W-1:0]  sel;
      logic [trc_pkg::DATA_W-1:0] data;
      timer_clear();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_item(DIRECTED_STIM[r].cmd, DIRECTED_STIM[r].sel, DIRECTED_STIM[r].data,
                   DIRECTED_STIM[r].fixed, DIRECTED_STIM[r].result);

      burst_left = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0 && !holdoff_active) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 55)      cmd = trc_pkg::CMD_TICK;
         else if (pick < 75) cmd = trc_pkg::CMD_READ;
         else if (pick < 97) cmd = trc_pkg::CMD_WRITE;
         else                cmd = CMD_UNUSED;
         if ($urandom_range(0, 9) == 0)
            sel = trc_pkg::SEL_W'($urandom_range(SEL_UNMAPPED, SEL_TOP));
         else
            sel = trc_pkg::SEL_W'($urandom_range(SEL_OUTCTL, SEL_CONTROL2));
         data = $urandom;
         // bias writes toward short counts and fast prescales so channels underflow often
         if (cmd == trc_pkg::CMD_WRITE) begin
            if (sel == SEL_START) begin
               if ($urandom_range(0, 2) != 0) data[trc_pkg::NUM_CHANNELS-1:0] = '1;
            end else if (sel >= SEL_RELOAD0 && sel <= SEL_CONTROL2) begin
               kind = (int'(sel) - SEL_CH_BASE) % SEL_STRIDE;
               if (kind == KIND_CONTROL) begin
                  if ($urandom_range(0, 3) != 0)
                     data[trc_pkg::PSC_W-1:0] = trc_pkg::PSC_W'($urandom_range(0, 1));
                  else
                     data[trc_pkg::PSC_W-1:0] = trc_pkg::PSC_W'($urandom_range(2, 7));
               end else if ($urandom_range(0, 3) != 0) begin
                  data = $urandom_range(0, 5);
               end
            end
         end
         send_item(cmd, sel, data, 1'b0, '0);
         burst_left--;
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d items (%0d directed), %0d results checked, %0d errors",
               items_accepted, DIRECTED_ROWS, results_checked, error_count);
      $display("run: %0d channel interrupts, %0d-cycle receiver hold-off %s",
               irq_predicted, HOLDOFF_CYCLES, holdoff_done ? "done" : "not reached");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
